// File: rtl/crt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crt_pkg
// Shared types and constants of the command retransmit tracker.
// ----------------------------------------------------------------------------
package crt_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int CNT_W = $clog2(SLOT_COUNT);
    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

    localparam logic [1:0] KIND_SEND    = 2'd0;
    localparam logic [1:0] KIND_ACK     = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    localparam logic [1:0] EV_RESEND      = 2'd0;
    localparam logic [1:0] EV_TIMEOUT     = 2'd1;
    localparam logic [1:0] EV_ACK_OK      = 2'd2;
    localparam logic [1:0] EV_ACK_UNKNOWN = 2'd3;

    localparam logic REG_INTERVAL = 1'b0;
    localparam logic REG_RETRIES  = 1'b1;

    typedef struct packed {
        logic        valid;
        logic [15:0] age;
        logic [7:0]  retries;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

endpackage
`default_nettype wire

// File: rtl/crt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crt_cell
// One slot entry of the rotating ring; takes its neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module crt_cell
    import crt_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_shift,
    input  wire t_entry i_d,
    output t_entry      o_q
);

    t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule
`default_nettype wire

// File: rtl/command_retransmit_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// command_retransmit_tracker
// Busy stays high while an item is processed: one ring rotation past the
// head cell in the scan state, then the flush state. A found result is held
// until the next one is found or the flush, and shows in the cycle after;
// the final one follows the flush. A new item is taken only after busy falls;
// the receiver cannot stall. Synchronous active-low reset frees all slots and
// loads the register defaults.
// ----------------------------------------------------------------------------
module command_retransmit_tracker
    import crt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_kind,
    input  wire logic [5:0]  i_cmd_num,
    output logic             o_strobe,
    output logic [1:0]       o_event_res,
    output logic [5:0]       o_slot_num,
    output logic [7:0]       o_retry_num,
    output logic             o_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [1:0] r_kind;
    logic [5:0] r_num;
    logic [15:0] r_interval;
    logic [7:0] r_max;
    logic r_hold_v, n_hold_v;
    logic [1:0] r_hold_ev, n_hold_ev;
    logic [5:0] r_hold_slot, n_hold_slot;
    logic [7:0] r_hold_retry, n_hold_retry;
    logic n_out_v, n_out_last;
    logic [1:0] n_out_ev;
    logic [5:0] n_out_slot;
    logic [7:0] n_out_retry;
    t_entry ring_q [SLOT_COUNT];
    t_entry head_d;
    logic shift;
    logic [16:0] age_inc;
    logic match;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (start) n_state = ST_SCAN;
            ST_SCAN:  if (r_cnt == CNT_W'(SLOT_COUNT - 1)) n_state = ST_FLUSH;
            ST_FLUSH: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    assign busy = (r_state != ST_IDLE);
    assign shift = (r_state == ST_SCAN);
    assign match = (CMP_W'(r_num) == CMP_W'(r_cnt));
    assign age_inc = {1'b0, ring_q[0].age} + 17'd1;

    always_comb begin
        head_d = ring_q[0];
        n_hold_v = r_hold_v;
        n_hold_ev = r_hold_ev;
        n_hold_slot = r_hold_slot;
        n_hold_retry = r_hold_retry;
        n_out_v = 1'b0;
        n_out_last = 1'b0;
        n_out_ev = r_hold_ev;
        n_out_slot = r_hold_slot;
        n_out_retry = r_hold_retry;
        if (r_state == ST_SCAN) begin
            logic found;
            logic [1:0] f_ev;
            logic [7:0] f_retry;
            found = 1'b0;
            f_ev = EV_RESEND;
            f_retry = 8'd0;
            unique case (r_kind)
                KIND_SEND: if (match) begin
                    head_d.valid = 1'b1;
                    head_d.age = 16'd0;
                    head_d.retries = 8'd0;
                end
                KIND_ACK: if (match) begin
                    found = 1'b1;
                    f_ev = ring_q[0].valid ? EV_ACK_OK : EV_ACK_UNKNOWN;
                    head_d.valid = 1'b0;
                end
                KIND_TICK: if (ring_q[0].valid) begin
                    if (age_inc >= {1'b0, r_interval}) begin
                        found = 1'b1;
                        if (ring_q[0].retries < r_max) begin
                            head_d.retries = ring_q[0].retries + 8'd1;
                            head_d.age = 16'd0;
                            f_retry = head_d.retries;
                        end else begin
                            head_d.valid = 1'b0;
                            f_ev = EV_TIMEOUT;
                        end
                    end else begin
                        head_d.age = age_inc[15:0];
                    end
                end
                default: ;
            endcase
            if (found) begin
                n_out_v = r_hold_v;
                n_hold_v = 1'b1;
                n_hold_ev = f_ev;
                n_hold_slot = 6'(r_cnt);
                n_hold_retry = f_retry;
            end
        end else if (r_state == ST_FLUSH) begin
            n_hold_v = 1'b0;
            n_out_last = 1'b1;
            if (r_hold_v) begin
                n_out_v = 1'b1;
            end else if (r_kind == KIND_ACK) begin
                n_out_v = 1'b1;
                n_out_ev = EV_ACK_UNKNOWN;
                n_out_slot = r_num;
                n_out_retry = 8'd0;
            end
        end
    end

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_ring
        crt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_d     ((g == SLOT_COUNT - 1) ? head_d : ring_q[(g + 1) % SLOT_COUNT]),
            .o_q     (ring_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt <= '0;
            r_hold_v <= 1'b0;
            o_strobe <= 1'b0;
            r_interval <= 16'd1000;
            r_max <= 8'd3;
        end else begin
            r_state <= n_state;
            r_hold_v <= n_hold_v;
            o_strobe <= n_out_v;
            if (r_state == ST_SCAN) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end
            if (psel && penable && pwrite) begin
                if (paddr[2] == REG_INTERVAL) r_interval <= pwdata[15:0];
                else r_max <= pwdata[7:0];
            end
        end
        if (r_state == ST_IDLE && start) begin
            r_kind <= i_kind;
            r_num <= i_cmd_num;
        end
        r_hold_ev <= n_hold_ev;
        r_hold_slot <= n_hold_slot;
        r_hold_retry <= n_hold_retry;
        o_event_res <= n_out_ev;
        o_slot_num <= n_out_slot;
        o_retry_num <= n_out_retry;
        o_last <= n_out_last;
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RETRIES) ? {24'd0, r_max} : {16'd0, r_interval};

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the command retransmit tracker. Send, ack and tick commands
// are driven through the start/busy handshake with random gaps, and the two
// registers are rewritten over the APB port between phases. A scoreboard
// keeps its own copy of the slot table and checks every event transfer.
// ----------------------------------------------------------------------------
module tb_top;
    import crt_pkg::*;

    localparam int RUN_LIMIT = 2000000;
    localparam int SETTLE    = 80;

    typedef struct {
        logic [1:0] ev;
        logic [5:0] slot;
        logic [7:0] retry;
        logic       last;
    } t_event;

    class retx_scoreboard;
        logic [15:0] interval;
        logic [7:0]  max_retry;
        logic        armed [SLOT_COUNT];
        logic [15:0] age   [SLOT_COUNT];
        logic [7:0]  tries [SLOT_COUNT];
        t_event      due_q [$];
        int          errors;

        function new();
            interval  = 16'd1000;
            max_retry = 8'd3;
            errors    = 0;
            for (int s = 0; s < SLOT_COUNT; s++) begin
                armed[s] = 1'b0;
                age[s]   = '0;
                tries[s] = '0;
            end
        endfunction

        function void push_event(logic [1:0] ev, int slot, logic [7:0] retry);
            t_event e;
            e.ev    = ev;
            e.slot  = slot[5:0];
            e.retry = retry;
            e.last  = 1'b0;
            due_q.insert(due_q.size(), e);
        endfunction

        function void note_item(logic [1:0] kind, logic [5:0] num);
            int found;
            int next_age;
            int lim;
            found = 0;
            if (kind == KIND_SEND) begin
                armed[num] = 1'b1;
                age[num]   = '0;
                tries[num] = '0;
            end else if (kind == KIND_ACK) begin
                push_event(armed[num] ? EV_ACK_OK : EV_ACK_UNKNOWN, num, 8'd0);
                armed[num] = 1'b0;
                due_q[$].last = 1'b1;
            end else if (kind == KIND_TICK) begin
                lim = (interval == 0) ? 1 : interval;
                for (int s = 0; s < SLOT_COUNT; s++) begin
                    if (armed[s]) begin
                        next_age = age[s] + 1;
                        if (next_age > 65535) next_age = 65535;
                        if (next_age >= lim) begin
                            if (tries[s] < max_retry) begin
                                tries[s] = tries[s] + 8'd1;
                                age[s]   = '0;
                                push_event(EV_RESEND, s, tries[s]);
                            end else begin
                                armed[s] = 1'b0;
                                push_event(EV_TIMEOUT, s, 8'd0);
                            end
                            found++;
                        end else begin
                            age[s] = next_age[15:0];
                        end
                    end
                end
                if (found > 0) due_q[$].last = 1'b1;
            end
        endfunction

        function void check_event(logic [1:0] ev, logic [5:0] slot, logic [7:0] retry,
                                  logic last);
            t_event e;
            if (due_q.size() == 0) begin
                $error("Unexpected event transfer: event %0d slot %0d", ev, slot);
                errors++;
                return;
            end
            e = due_q.pop_front();
            if (ev !== e.ev) begin
                $error("event_res: expected %0d, got %0d", e.ev, ev);
                errors++;
            end
            if (slot !== e.slot) begin
                $error("slot_num: expected %0d, got %0d", e.slot, slot);
                errors++;
            end
            if (retry !== e.retry) begin
                $error("retry_num: expected %0d, got %0d", e.retry, retry);
                errors++;
            end
            if (last !== e.last) begin
                $error("last: expected %0d, got %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_kind = '0;
    logic [5:0]  i_cmd_num = '0;
    logic        o_strobe;
    logic [1:0]  o_event_res;
    logic [5:0]  o_slot_num;
    logic [7:0]  o_retry_num;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          cycles = 0;

    retx_scoreboard sb = new();

    command_retransmit_tracker u_top (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_event(o_event_res, o_slot_num, o_retry_num, o_last);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(20, 90);
    endfunction

    task automatic issue(logic [1:0] kind, logic [5:0] num);
        int gap;
        start     <= 1'b1;
        i_kind    <= kind;
        i_cmd_num <= num;
        do @(posedge i_clk); while (busy);
        sb.note_item(kind, num);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic addr_sel, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {addr_sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr_sel == REG_INTERVAL) sb.interval = value[15:0];
        else sb.max_retry = value[7:0];
    endtask

    task automatic set_config(logic [15:0] ivl, logic [7:0] mr);
        drain();
        write_reg(REG_INTERVAL, {16'h0, ivl});
        write_reg(REG_RETRIES, {24'h0, mr});
    endtask

    task automatic random_phase(int count, int tick_pct);
        int r;
        logic [5:0] num;
        for (int k = 0; k < count; k++) begin
            r   = $urandom_range(0, 99);
            num = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(0, 7));
            if (r < tick_pct) issue(KIND_TICK, 6'($urandom));
            else if (r < tick_pct + (100 - tick_pct) / 2) issue(KIND_SEND, num);
            else if (r < 97) issue(KIND_ACK, num);
            else issue(KIND_IGNORED, num);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(KIND_TICK, 6'd0);
        issue(KIND_ACK, 6'd5);
        issue(KIND_SEND, 6'd0);
        issue(KIND_SEND, 6'd63);
        issue(KIND_SEND, 6'd0);
        issue(KIND_ACK, 6'd0);
        issue(KIND_ACK, 6'd0);
        issue(KIND_IGNORED, 6'd42);
        issue(KIND_ACK, 6'd63);

        set_config(16'd1, 8'd0);
        issue(KIND_SEND, 6'd1);
        issue(KIND_SEND, 6'd2);
        issue(KIND_SEND, 6'd63);
        issue(KIND_TICK, 6'd63);
        issue(KIND_TICK, 6'd0);

        set_config(16'd2, 8'd255);
        issue(KIND_SEND, 6'd10);
        issue(KIND_SEND, 6'd21);
        issue(KIND_TICK, 6'd0);
        issue(KIND_SEND, 6'd21);
        issue(KIND_TICK, 6'd0);
        issue(KIND_TICK, 6'd0);
        issue(KIND_ACK, 6'd10);

        set_config(16'd1, 8'd2);
        for (int s = 0; s < SLOT_COUNT; s++) issue(KIND_SEND, 6'(s));
        repeat (3) issue(KIND_TICK, 6'h3f);

        set_config(16'd3, 8'd1);
        random_phase(8, 40);
        set_config(16'd65535, 8'd255);
        random_phase(6, 40);
        set_config(16'd2, 8'd2);
        random_phase(8, 45);
        set_config(16'd1, 8'd0);
        random_phase(6, 40);
        set_config(16'd4, 8'd3);
        random_phase(8, 50);
        set_config(16'd1, 8'd255);
        random_phase(6, 40);
        issue(KIND_SEND, 6'd7);
        issue(KIND_TICK, 6'd0);

        drain();
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/crt_pkg.sv
rtl/crt_cell.sv
rtl/command_retransmit_tracker.sv
bench/tb_top.sv
